FILE: hw/rtl/v3vu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3vu_pkg
// Shared widths, constants, opcodes and helper functions of the vector unit.
// ----------------------------------------------------------------------------
package v3vu_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ANG_BITS     = 30;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int AB = ANG_BITS;
  localparam int NS = CORDIC_STEPS;

  localparam longint ONE_A     = longint'(1) << AB;
  localparam longint PI_A      = 64'sd3373259426;
  localparam longint HALF_PI_A = 64'sd1686629713;
  localparam longint TWO_PI_A  = 64'sd6746518852;
  localparam longint GAIN_A    = 64'sd652032874;

  // sine/cosine word, normalised unit vector, scaled products
  localparam int CW  = AB + 4;
  localparam int KW  = F + 2;
  localparam int PW  = 2 * W - F;
  localparam int TW  = PW + 1;
  localparam int DW  = PW + 2;
  localparam int RDW = W + 3;
  localparam int ACW = W + CW - AB;
  localparam int TSW = RDW + CW - AB;
  localparam int DMW = RDW + CW + 1 - AB;
  localparam int KDW = KW + DMW - F;
  localparam int RVW = KDW + 2;
  localparam int VW  = (RVW > DW) ? RVW : DW;

  // angle reduction
  localparam int RW        = W + AB - F;
  localparam int MW        = RW + 2;
  localparam int FW        = CW + 1;
  localparam int MOD_STEPS = $clog2(((longint'(1) << (RW - 1)) / TWO_PI_A) + 1);

  // latencies and stage numbers, counted in registers after the input beat
  localparam int ISQRT_LAT = W;
  localparam int DIV_LAT   = F + 1;
  localparam int SC_LAT    = MOD_STEPS + NS + 5;
  localparam int BK_LAT    = 5;
  localparam int ST_IN     = 1;
  localparam int ST_SUM    = 3;
  localparam int ST_LEN    = ST_SUM + ISQRT_LAT;
  localparam int ST_Q      = ST_LEN + DIV_LAT;
  localparam int ST_K      = ST_Q + 1;
  localparam int ST_SC     = ST_K - SC_LAT;
  localparam int ST_V      = ST_K + BK_LAT;
  localparam int ST_OUT    = ST_V + 1;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_SCALE = 4'd2,
    OP_MUL   = 4'd3,
    OP_CROSS = 4'd4,
    OP_DOT   = 4'd5,
    OP_LEN   = 4'd6,
    OP_NORM  = 4'd7,
    OP_ROT   = 4'd8
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [2:0][W-1:0]   a;
    logic [2:0][W-1:0]   b;
    logic [W-1:0]        sc;
  } item_t;

  typedef struct packed {
    logic is_vec;
    logic is_scal;
    logic zl;
  } flags_t;

  typedef struct packed {
    logic [W-1:0] val;
    logic         sat;
  } clip_t;

  function automatic longint atan_c(input int i);
    case (i)
      0:  atan_c = 843314856;
      1:  atan_c = 497837829;
      2:  atan_c = 263043836;
      3:  atan_c = 133525158;
      4:  atan_c = 67021686;
      5:  atan_c = 33543515;
      6:  atan_c = 16775850;
      7:  atan_c = 8388437;
      8:  atan_c = 4194282;
      9:  atan_c = 2097149;
      10: atan_c = 1048575;
      11: atan_c = 524287;
      12: atan_c = 262143;
      13: atan_c = 131071;
      14: atan_c = 65535;
      15: atan_c = 32767;
      16: atan_c = 16383;
      17: atan_c = 8191;
      18: atan_c = 4095;
      19: atan_c = 2047;
      20: atan_c = 1023;
      21: atan_c = 511;
      22: atan_c = 255;
      23: atan_c = 127;
      24: atan_c = 63;
      25: atan_c = 31;
      26: atan_c = 15;
      27: atan_c = 8;
      28: atan_c = 4;
      29: atan_c = 2;
      30: atan_c = 1;
      default: atan_c = 0;
    endcase
  endfunction

  // vector whose length drives the square root: the axis for rotate
  function automatic logic [2:0][W-1:0] norm_src(input item_t it);
    norm_src = (it.op == OP_ROT) ? it.b : it.a;
  endfunction

  function automatic clip_t clip_w(input logic signed [VW-1:0] v);
    clip_t r;
    if (&v[VW-1:W-1] || ~|v[VW-1:W-1]) begin
      r.val = v[W-1:0];
      r.sat = 1'b0;
    end else begin
      r.val = v[VW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      r.sat = 1'b1;
    end
    clip_w = r;
  endfunction

endpackage

FILE: hw/rtl/v3vu_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3vu_isqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module v3vu_isqrt import v3vu_pkg::*; (
  input  logic           clk,
  input  logic [2*W-1:0] sq_in,
  output logic [W-1:0]   root
);

  logic [2*W-1:0] s_r [1:W];
  logic [2*W-1:0] q_r [1:W];

  for (genvar i = 0; i < W; i++) begin : g_step
    logic [2*W-1:0] s_prev, q_prev, bitv, s_nxt, q_nxt;
    logic [2*W:0]   cand;
    if (i == 0) begin : g_first
      assign s_prev = sq_in;
      assign q_prev = '0;
    end else begin : g_next
      assign s_prev = s_r[i];
      assign q_prev = q_r[i];
    end
    assign bitv = (2*W)'(1) << (2*W - 2 - 2*i);
    assign cand = {1'b0, q_prev} + {1'b0, bitv};
    always_comb begin
      if ({1'b0, s_prev} >= cand) begin
        s_nxt = s_prev - cand[2*W-1:0];
        q_nxt = (q_prev >> 1) + bitv;
      end else begin
        s_nxt = s_prev;
        q_nxt = q_prev >> 1;
      end
    end
    always_ff @(posedge clk) begin
      s_r[i+1] <= s_nxt;
      q_r[i+1] <= q_nxt;
    end
  end

  assign root = q_r[W][W-1:0];

endmodule

FILE: hw/rtl/v3vu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3vu_div
// Pipelined restoring divide of a fraction-scaled magnitude by a length.
// ----------------------------------------------------------------------------
module v3vu_div import v3vu_pkg::*; (
  input  logic         clk,
  input  logic [W-1:0] num_mag,
  input  logic [W-1:0] den,
  output logic [F:0]   quo
);

  localparam int NW = W + F + 1;

  logic [NW-1:0] rem_r [1:F+1];
  logic [W-1:0]  den_r [1:F+1];
  logic [F:0]    q_r   [1:F+1];

  for (genvar j = 0; j <= F; j++) begin : g_step
    logic [NW-1:0] rem_prev, dv, rem_nxt;
    logic [W-1:0]  den_prev;
    logic [F:0]    q_prev;
    logic          take;
    if (j == 0) begin : g_first
      assign rem_prev = {1'b0, num_mag, {F{1'b0}}};
      assign den_prev = den;
      assign q_prev   = '0;
    end else begin : g_next
      assign rem_prev = rem_r[j];
      assign den_prev = den_r[j];
      assign q_prev   = q_r[j];
    end
    assign dv      = NW'(den_prev) << (F - j);
    assign take    = rem_prev >= dv;
    assign rem_nxt = take ? rem_prev - dv : rem_prev;
    always_ff @(posedge clk) begin
      rem_r[j+1] <= rem_nxt;
      den_r[j+1] <= den_prev;
      q_r[j+1]   <= {q_prev[F-1:0], take};
    end
  end

  assign quo = q_r[F+1];

endmodule

FILE: hw/rtl/v3vu_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3vu_sincos
// Angle reduction to a quarter turn, then a pipelined rotation-mode CORDIC.
// ----------------------------------------------------------------------------
module v3vu_sincos import v3vu_pkg::*; (
  input  logic                 clk,
  input  logic signed [W-1:0]  angle,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o
);

  localparam logic signed [CW-1:0] GAIN_C = CW'(GAIN_A);
  localparam logic signed [FW-1:0] T_F    = FW'(TWO_PI_A);
  localparam logic signed [FW-1:0] PI_F   = FW'(PI_A);
  localparam logic signed [FW-1:0] HP_F   = FW'(HALF_PI_A);

  logic signed [RW-1:0] r_full;
  logic [RW-1:0]        r_mag;
  logic [MW-1:0]        rem_r [0:MOD_STEPS];
  logic                 sg_r  [0:MOD_STEPS];
  logic signed [FW-1:0] f1_r, f2_r, m_s;
  logic signed [CW-1:0] z_r   [0:NS];
  logic                 nq_r  [0:NS];
  logic signed [CW-1:0] x_r   [1:NS];
  logic signed [CW-1:0] y_r   [1:NS];
  logic signed [CW-1:0] cos_r, sin_r;

  assign r_full = RW'(angle) <<< (AB - F);
  assign r_mag  = r_full[RW-1] ? RW'(-r_full) : RW'(r_full);

  always_ff @(posedge clk) begin
    rem_r[0] <= MW'(r_mag);
    sg_r[0]  <= r_full[RW-1];
  end

  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    logic [MW-1:0] tv;
    assign tv = MW'(TWO_PI_A) << (MOD_STEPS - 1 - j);
    always_ff @(posedge clk) begin
      rem_r[j+1] <= (rem_r[j] >= tv) ? rem_r[j] - tv : rem_r[j];
      sg_r[j+1]  <= sg_r[j];
    end
  end

  assign m_s = $signed({1'b0, rem_r[MOD_STEPS][FW-2:0]});

  always_ff @(posedge clk) begin
    f1_r <= (sg_r[MOD_STEPS] && (m_s != '0)) ? T_F - m_s : m_s;
    f2_r <= (f1_r > PI_F) ? f1_r - T_F : f1_r;
    if (f2_r > HP_F) begin
      z_r[0]  <= CW'(f2_r - PI_F);
      nq_r[0] <= 1'b1;
    end else if (f2_r < -HP_F) begin
      z_r[0]  <= CW'(f2_r + PI_F);
      nq_r[0] <= 1'b1;
    end else begin
      z_r[0]  <= CW'(f2_r);
      nq_r[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    logic signed [CW-1:0] x_prev, y_prev, atn;
    if (i == 0) begin : g_first
      assign x_prev = GAIN_C;
      assign y_prev = '0;
    end else begin : g_next
      assign x_prev = x_r[i];
      assign y_prev = y_r[i];
    end
    assign atn = CW'(atan_c(i));
    always_ff @(posedge clk) begin
      if (z_r[i] >= 0) begin
        x_r[i+1] <= x_prev - (y_prev >>> i);
        y_r[i+1] <= y_prev + (x_prev >>> i);
        z_r[i+1] <= z_r[i] - atn;
      end else begin
        x_r[i+1] <= x_prev + (y_prev >>> i);
        y_r[i+1] <= y_prev - (x_prev >>> i);
        z_r[i+1] <= z_r[i] + atn;
      end
      nq_r[i+1] <= nq_r[i];
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= nq_r[NS] ? -x_r[NS] : x_r[NS];
    sin_r <= nq_r[NS] ? -y_r[NS] : y_r[NS];
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

FILE: hw/rtl/v3vu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v3vu_back
// Vector arithmetic back end: shared products, sums and the rotation terms.
// ----------------------------------------------------------------------------
module v3vu_back import v3vu_pkg::*; (
  input  logic                 clk,
  input  item_t                itm,
  input  logic signed [KW-1:0] k [3],
  input  logic                 zl,
  input  logic [W-1:0]         len,
  input  logic signed [CW-1:0] cs_c,
  input  logic signed [CW-1:0] cs_s,
  output logic signed [VW-1:0] v [3],
  output logic signed [VW-1:0] scal,
  output flags_t               flg
);

  logic signed [W-1:0]    a_s [3];
  logic signed [W-1:0]    b_s [3];
  logic signed [W-1:0]    u   [3];
  logic signed [W-1:0]    w   [3];
  logic signed [W-1:0]    wd  [3];
  logic signed [W-1:0]    sc_s;

  // stage 1
  logic signed [PW-1:0]   pd1_r [3];
  logic signed [PW-1:0]   pca1_r [3];
  logic signed [PW-1:0]   pcb1_r [3];
  logic signed [ACW-1:0]  ac1_r [3];
  logic signed [W:0]      as1_r [3];
  logic signed [KW-1:0]   k1_r [3];
  logic signed [CW:0]     omc1_r;
  logic signed [CW-1:0]   s1_r;
  logic [W-1:0]           len1_r;
  op_t                    op1_r;
  logic                   zl1_r;

  // stage 2
  logic signed [TW-1:0]   t_c [3];
  logic signed [DW-1:0]   dot_c;
  logic signed [VW-1:0]   vs_c [3];
  logic signed [VW-1:0]   scal_c;
  logic signed [TW-1:0]   t2_r [3];
  logic signed [DW-1:0]   dot2_r;
  logic signed [VW-1:0]   vs2_r [3];
  logic signed [VW-1:0]   scal2_r;
  logic signed [ACW-1:0]  ac2_r [3];
  logic signed [KW-1:0]   k2_r [3];
  logic signed [CW:0]     omc2_r;
  logic signed [CW-1:0]   s2_r;
  op_t                    op2_r;
  logic                   zl2_r;

  // stage 3
  logic signed [RDW-1:0]        dot_t;
  logic signed [RDW+CW:0]       dm_p;
  logic signed [DMW-1:0]        dm3_r;
  logic signed [TSW-1:0]        ts3_r [3];
  logic signed [ACW-1:0]        ac3_r [3];
  logic signed [KW-1:0]         k3_r [3];
  logic signed [VW-1:0]         vs3_r [3];
  logic signed [VW-1:0]         scal3_r;
  op_t                          op3_r;
  logic                         zl3_r;

  // stage 4
  logic signed [KDW-1:0]  kd4_r [3];
  logic signed [TSW-1:0]  ts4_r [3];
  logic signed [ACW-1:0]  ac4_r [3];
  logic signed [VW-1:0]   vs4_r [3];
  logic signed [VW-1:0]   scal4_r;
  op_t                    op4_r;
  logic                   zl4_r;

  // stage 5
  logic signed [VW-1:0]   v5_r [3];
  logic signed [VW-1:0]   scal5_r;
  flags_t                 flg5_r;

  assign sc_s = $signed(itm.sc);

  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;
    logic signed [2*W-1:0]    pd_p, pca_p, pcb_p;
    logic signed [W+CW-1:0]   ac_p;
    logic signed [RDW-1:0]    t_t;
    logic signed [RDW+CW-1:0] ts_p;
    logic signed [KW+DMW-1:0] kd_p;

    assign a_s[i] = $signed(itm.a[i]);
    assign b_s[i] = $signed(itm.b[i]);
    assign u[i]   = (itm.op == OP_ROT) ? W'(k[i]) : a_s[i];
    assign w[i]   = (itm.op == OP_ROT) ? a_s[i] : b_s[i];
    assign wd[i]  = (itm.op == OP_SCALE) ? sc_s : w[i];

    assign pd_p  = u[i] * wd[i];
    assign pca_p = u[I1] * w[I2];
    assign pcb_p = u[I2] * w[I1];
    assign ac_p  = a_s[i] * cs_c;

    always_ff @(posedge clk) begin
      pd1_r[i]  <= pd_p[2*W-1:F];
      pca1_r[i] <= pca_p[2*W-1:F];
      pcb1_r[i] <= pcb_p[2*W-1:F];
      ac1_r[i]  <= ac_p[W+CW-1:AB];
      as1_r[i]  <= (itm.op == OP_SUB) ? a_s[i] - b_s[i] : a_s[i] + b_s[i];
      k1_r[i]   <= k[i];
    end

    assign t_c[i] = TW'(pca1_r[i]) - TW'(pcb1_r[i]);

    always_comb begin
      case (op1_r)
        OP_ADD, OP_SUB:   vs_c[i] = VW'(as1_r[i]);
        OP_SCALE, OP_MUL: vs_c[i] = VW'(pd1_r[i]);
        OP_CROSS:         vs_c[i] = VW'(t_c[i]);
        OP_NORM:          vs_c[i] = VW'(k1_r[i]);
        default:          vs_c[i] = '0;
      endcase
    end

    assign t_t  = t2_r[i][RDW-1:0];
    assign ts_p = t_t * s2_r;
    assign kd_p = k3_r[i] * dm3_r;

    always_ff @(posedge clk) begin
      t2_r[i]  <= t_c[i];
      vs2_r[i] <= vs_c[i];
      ac2_r[i] <= ac1_r[i];
      k2_r[i]  <= k1_r[i];

      ts3_r[i] <= ts_p[RDW+CW-1:AB];
      ac3_r[i] <= ac2_r[i];
      k3_r[i]  <= k2_r[i];
      vs3_r[i] <= vs2_r[i];

      kd4_r[i] <= kd_p[KW+DMW-1:F];
      ts4_r[i] <= ts3_r[i];
      ac4_r[i] <= ac3_r[i];
      vs4_r[i] <= vs3_r[i];

      v5_r[i]  <= (op4_r == OP_ROT) ?
                  VW'(ac4_r[i]) + VW'(ts4_r[i]) + VW'(kd4_r[i]) : vs4_r[i];
    end

    assign v[i] = v5_r[i];
  end

  assign dot_c = DW'(pd1_r[0]) + DW'(pd1_r[1]) + DW'(pd1_r[2]);

  always_comb begin
    case (op1_r)
      OP_DOT:  scal_c = VW'(dot_c);
      OP_LEN:  scal_c = VW'({1'b0, len1_r});
      default: scal_c = '0;
    endcase
  end

  assign dot_t = dot2_r[RDW-1:0];
  assign dm_p  = dot_t * omc2_r;

  always_ff @(posedge clk) begin
    omc1_r  <= (CW+1)'(ONE_A) - (CW+1)'(cs_c);
    s1_r    <= cs_s;
    len1_r  <= len;
    op1_r   <= itm.op;
    zl1_r   <= zl;

    dot2_r  <= dot_c;
    scal2_r <= scal_c;
    omc2_r  <= omc1_r;
    s2_r    <= s1_r;
    op2_r   <= op1_r;
    zl2_r   <= zl1_r;

    dm3_r   <= dm_p[RDW+CW:AB];
    scal3_r <= scal2_r;
    op3_r   <= op2_r;
    zl3_r   <= zl2_r;

    scal4_r <= scal3_r;
    op4_r   <= op3_r;
    zl4_r   <= zl3_r;

    scal5_r <= scal4_r;
    flg5_r.is_vec  <= (op4_r == OP_ADD) || (op4_r == OP_SUB) || (op4_r == OP_SCALE) ||
                      (op4_r == OP_MUL) || (op4_r == OP_CROSS) || (op4_r == OP_NORM) ||
                      (op4_r == OP_ROT);
    flg5_r.is_scal <= (op4_r == OP_DOT) || (op4_r == OP_LEN);
    flg5_r.zl      <= zl4_r && ((op4_r == OP_NORM) || (op4_r == OP_ROT));
  end

  assign scal = scal5_r;
  assign flg  = flg5_r;

endmodule

FILE: hw/rtl/vec3_fixed_point_vector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_fixed_point_vector_unit
// The delay from the start beat to the out_valid strobe is set by the
// 32-stage square root followed by the 17-stage divide for normalising.
// Throughput: one beat per cycle; busy stays low and results are never held.
// Reset clears the valid pipeline only; items in flight are dropped.
// ----------------------------------------------------------------------------
module vec3_fixed_point_vector_unit import v3vu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [3:0]          in_op,
  input  logic signed [W-1:0] in_vec_a_x,
  input  logic signed [W-1:0] in_vec_a_y,
  input  logic signed [W-1:0] in_vec_a_z,
  input  logic signed [W-1:0] in_vec_b_x,
  input  logic signed [W-1:0] in_vec_b_y,
  input  logic signed [W-1:0] in_vec_b_z,
  input  logic signed [W-1:0] in_scalar_in,
  output logic                out_valid,
  output logic signed [W-1:0] out_res_x,
  output logic signed [W-1:0] out_res_y,
  output logic signed [W-1:0] out_res_z,
  output logic signed [W-1:0] out_res_scalar,
  output logic                out_zero_length,
  output logic                out_saturated
);

  logic                 vld_r [ST_IN:ST_OUT];
  item_t                itm_r [ST_IN:ST_K];
  logic [2*W-1:0]       sq_r  [3];
  logic [2*W-1:0]       sum_r;
  logic [W-1:0]         len_w;
  logic [W-1:0]         len_d [ST_LEN+1:ST_K];
  logic [2:0][W-1:0]    src_in, src_len, src_q;
  logic [W-1:0]         mag_in [3];
  logic [W-1:0]         mag_len [3];
  logic [F:0]           quo_w [3];
  logic signed [KW-1:0] k_r [3];
  logic                 zl_r;
  logic signed [CW-1:0] c_w, s_w;
  logic signed [VW-1:0] v_w [3];
  logic signed [VW-1:0] scal_w;
  flags_t               flg_w;
  clip_t                cx, cy, cz, csc;
  logic signed [W-1:0]  res_x_r, res_y_r, res_z_r, res_s_r;
  logic                 zl_out_r, sat_out_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = ST_IN; j <= ST_OUT; j++) vld_r[j] <= 1'b0;
    end else begin
      vld_r[ST_IN] <= start && !busy;
      for (int j = ST_IN; j < ST_OUT; j++) vld_r[j+1] <= vld_r[j];
    end
  end

  always_ff @(posedge clk) begin
    itm_r[ST_IN].op <= op_t'(in_op);
    itm_r[ST_IN].a  <= {in_vec_a_z, in_vec_a_y, in_vec_a_x};
    itm_r[ST_IN].b  <= {in_vec_b_z, in_vec_b_y, in_vec_b_x};
    itm_r[ST_IN].sc <= in_scalar_in;
    for (int j = ST_IN; j < ST_K; j++) itm_r[j+1] <= itm_r[j];
  end

  assign src_in  = norm_src(itm_r[ST_IN]);
  assign src_len = norm_src(itm_r[ST_LEN]);
  assign src_q   = norm_src(itm_r[ST_Q]);

  for (genvar i = 0; i < 3; i++) begin : g_mag
    assign mag_in[i]  = src_in[i][W-1] ? ~src_in[i] + 1'b1 : src_in[i];
    assign mag_len[i] = src_len[i][W-1] ? ~src_len[i] + 1'b1 : src_len[i];
    always_ff @(posedge clk) begin
      sq_r[i] <= mag_in[i] * mag_in[i];
    end

    v3vu_div u_div (
      .clk     (clk),
      .num_mag (mag_len[i]),
      .den     (len_w),
      .quo     (quo_w[i])
    );

    always_ff @(posedge clk) begin
      if (len_d[ST_Q] == '0) begin
        k_r[i] <= '0;
      end else if (src_q[i][W-1]) begin
        k_r[i] <= -$signed({1'b0, quo_w[i]});
      end else begin
        k_r[i] <= $signed({1'b0, quo_w[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sq_r[0] + sq_r[1] + sq_r[2];
    zl_r  <= len_d[ST_Q] == '0;
    len_d[ST_LEN+1] <= len_w;
    for (int j = ST_LEN + 1; j < ST_K; j++) len_d[j+1] <= len_d[j];
  end

  v3vu_isqrt u_isqrt (
    .clk   (clk),
    .sq_in (sum_r),
    .root  (len_w)
  );

  v3vu_sincos u_sincos (
    .clk   (clk),
    .angle ($signed(itm_r[ST_SC].sc)),
    .cos_o (c_w),
    .sin_o (s_w)
  );

  v3vu_back u_back (
    .clk  (clk),
    .itm  (itm_r[ST_K]),
    .k    (k_r),
    .zl   (zl_r),
    .len  (len_d[ST_K]),
    .cs_c (c_w),
    .cs_s (s_w),
    .v    (v_w),
    .scal (scal_w),
    .flg  (flg_w)
  );

  assign cx  = clip_w(v_w[0]);
  assign cy  = clip_w(v_w[1]);
  assign cz  = clip_w(v_w[2]);
  assign csc = clip_w(scal_w);

  always_ff @(posedge clk) begin
    res_x_r   <= flg_w.is_vec ? cx.val : '0;
    res_y_r   <= flg_w.is_vec ? cy.val : '0;
    res_z_r   <= flg_w.is_vec ? cz.val : '0;
    res_s_r   <= flg_w.is_scal ? csc.val : '0;
    zl_out_r  <= flg_w.zl;
    sat_out_r <= (flg_w.is_vec && (cx.sat || cy.sat || cz.sat)) ||
                 (flg_w.is_scal && csc.sat);
  end

  assign out_valid       = vld_r[ST_OUT];
  assign out_res_x       = res_x_r;
  assign out_res_y       = res_y_r;
  assign out_res_z       = res_z_r;
  assign out_res_scalar  = res_s_r;
  assign out_zero_length = zl_out_r;
  assign out_saturated   = sat_out_r;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3-vector fixed-point unit. Every opcode, the
// unknown opcodes, zero vectors, zero axes and saturating extremes are driven
// first, then random beats with random gaps. Each accepted beat is predicted
// in Q16.16 and the strobed results are compared in order.
// ----------------------------------------------------------------------------
module tb;
  import v3vu_pkg::*;

  localparam logic [3:0] OP_UNKNOWN    = 4'd9;
  localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;
  localparam int         TAIL          = 80;
  localparam int         WD_LIMIT      = 2000;
  localparam longint     QMAX          = 64'sd2147483647;
  localparam longint     QMIN          = -64'sd2147483648;
  localparam longint     ONE_Q         = 64'sd65536;

  typedef struct {
    logic [3:0]          op;
    logic signed [W-1:0] ax, ay, az, bx, by, bz, sc;
    int                  gap;
    bit                  drain;
  } beat_t;

  typedef struct {
    logic signed [W-1:0] x, y, z, s;
    logic                zl, sat;
  } vres_t;

  localparam longint ATAN_Q30 [16] = '{843314856, 497837829, 263043836, 133525158,
    67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_op = '0;
  logic signed [W-1:0] in_vec_a_x = '0, in_vec_a_y = '0, in_vec_a_z = '0;
  logic signed [W-1:0] in_vec_b_x = '0, in_vec_b_y = '0, in_vec_b_z = '0;
  logic signed [W-1:0] in_scalar_in = '0;
  logic out_valid, out_zero_length, out_saturated;
  logic signed [W-1:0] out_res_x, out_res_y, out_res_z, out_res_scalar;

  beat_t beats[$];
  vres_t expected_res[$];
  int    mismatches = 0;
  int    gap_left = 0;
  int    idle_cycles = 0;
  bit    stim_done = 1'b0;

  vec3_fixed_point_vector_unit dut (.*);

  always #10 clk = ~clk;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic signed [W-1:0] sat_word(longint v, inout logic sat);
    if (v > QMAX) begin
      v = QMAX;
      sat = 1'b1;
    end
    if (v < QMIN) begin
      v = QMIN;
      sat = 1'b1;
    end
    return v[W-1:0];
  endfunction

  function automatic longint unsigned vec_length(longint v [3]);
    longint unsigned acc, root, bitv;
    acc = 0;
    root = 0;
    for (int i = 0; i < 3; i++) acc += magn(v[i]) * magn(v[i]);
    for (int i = 0; i < 32; i++) begin
      bitv = 64'd1 << (62 - 2 * i);
      if (acc >= root + bitv) begin
        acc -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
    end
    return root;
  endfunction

  function automatic bit unit_vec(longint v [3], output longint k [3]);
    longint unsigned len, q;
    len = vec_length(v);
    k = '{0, 0, 0};
    if (len == 0) return 1'b1;
    for (int i = 0; i < 3; i++) begin
      q = (magn(v[i]) << F) / len;
      k[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic void cross3(longint a [3], longint b [3], output longint r [3]);
    r[0] = floor_shr(a[1] * b[2], F) - floor_shr(a[2] * b[1], F);
    r[1] = floor_shr(a[2] * b[0], F) - floor_shr(a[0] * b[2], F);
    r[2] = floor_shr(a[0] * b[1], F) - floor_shr(a[1] * b[0], F);
  endfunction

  function automatic longint dot3(longint a [3], longint b [3]);
    return floor_shr(a[0] * b[0], F) + floor_shr(a[1] * b[1], F) +
           floor_shr(a[2] * b[2], F);
  endfunction

  function automatic void cordic_cos_sin(longint ang, output longint c, output longint s);
    longint r, x, y, t;
    bit flip;
    r = ang * (longint'(1) << (AB - F));
    x = GAIN_A;
    y = 0;
    flip = 1'b0;
    r = r % TWO_PI_A;
    if (r < 0) r += TWO_PI_A;
    if (r > PI_A) r -= TWO_PI_A;
    if (r > HALF_PI_A) begin
      r -= PI_A;
      flip = 1'b1;
    end else if (r < -HALF_PI_A) begin
      r += PI_A;
      flip = 1'b1;
    end
    for (int i = 0; i < NS; i++) begin
      if (r >= 0) begin
        t = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        r -= ATAN_Q30[i];
      end else begin
        t = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        r += ATAN_Q30[i];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic vres_t vector_unit_result(beat_t b);
    longint a [3], bv [3], v [3], k [3], t [3];
    longint sc, scal, c, s, d;
    bit is_vec, is_scal;
    vres_t r;
    a = '{b.ax, b.ay, b.az};
    bv = '{b.bx, b.by, b.bz};
    v = '{0, 0, 0};
    sc = b.sc;
    scal = 0;
    is_vec = 1'b1;
    is_scal = 1'b0;
    r.zl = 1'b0;
    r.sat = 1'b0;
    case (b.op)
      OP_ADD:   for (int i = 0; i < 3; i++) v[i] = a[i] + bv[i];
      OP_SUB:   for (int i = 0; i < 3; i++) v[i] = a[i] - bv[i];
      OP_SCALE: for (int i = 0; i < 3; i++) v[i] = floor_shr(a[i] * sc, F);
      OP_MUL:   for (int i = 0; i < 3; i++) v[i] = floor_shr(a[i] * bv[i], F);
      OP_CROSS: cross3(a, bv, v);
      OP_DOT: begin
        scal = dot3(a, bv);
        is_vec = 1'b0;
        is_scal = 1'b1;
      end
      OP_LEN: begin
        scal = longint'(vec_length(a));
        is_vec = 1'b0;
        is_scal = 1'b1;
      end
      OP_NORM:  r.zl = unit_vec(a, v);
      OP_ROT: begin
        r.zl = unit_vec(bv, k);
        cordic_cos_sin(sc, c, s);
        cross3(k, a, t);
        d = floor_shr(dot3(k, a) * (ONE_A - c), AB);
        for (int i = 0; i < 3; i++)
          v[i] = floor_shr(a[i] * c, AB) + floor_shr(t[i] * s, AB) + floor_shr(k[i] * d, F);
      end
      default: is_vec = 1'b0;
    endcase
    r.x = is_vec ? sat_word(v[0], r.sat) : '0;
    r.y = is_vec ? sat_word(v[1], r.sat) : '0;
    r.z = is_vec ? sat_word(v[2], r.sat) : '0;
    r.s = is_scal ? sat_word(scal, r.sat) : '0;
    return r;
  endfunction

  function automatic logic signed [W-1:0] rand_comp(int kind);
    case (kind)
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      2:       return $signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return '0;
          3: return 32'sh0001_0000;
          4: return -32'sh0001_0000;
          default: return 32'shFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic beat_t mk(logic [3:0] op, longint ax, longint ay, longint az,
                               longint bx, longint by, longint bz, longint sc);
    beat_t b;
    b.op = op;
    b.ax = ax; b.ay = ay; b.az = az;
    b.bx = bx; b.by = by; b.bz = bz;
    b.sc = sc;
    b.gap = 0;
    b.drain = 1'b0;
    return b;
  endfunction

  always @(posedge clk) begin
    beat_t nb;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (beats.size() > 0 && !beats[0].drain) begin
        nb = beats.pop_front();
        in_op <= nb.op;
        in_vec_a_x <= nb.ax; in_vec_a_y <= nb.ay; in_vec_a_z <= nb.az;
        in_vec_b_x <= nb.bx; in_vec_b_y <= nb.by; in_vec_b_z <= nb.bz;
        in_scalar_in <= nb.sc;
        gap_left = nb.gap;
        start <= 1'b1;
      end else begin
        if (beats.size() > 0 && !start && expected_res.size() == 0)
          void'(beats.pop_front());
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    beat_t acc;
    vres_t e;
    if (rst_n) begin
      if (start && !busy || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) begin
        acc = mk(in_op, in_vec_a_x, in_vec_a_y, in_vec_a_z, in_vec_b_x, in_vec_b_y,
                 in_vec_b_z, in_scalar_in);
        expected_res.push_back(vector_unit_result(acc));
      end
      if (out_valid) begin
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          e = expected_res.pop_front();
          if (out_res_x !== e.x || out_res_y !== e.y || out_res_z !== e.z ||
              out_res_scalar !== e.s || out_zero_length !== e.zl ||
              out_saturated !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h %h zl=%b sat=%b got %h %h %h %h zl=%b sat=%b",
                       e.x, e.y, e.z, e.s, e.zl, e.sat, out_res_x, out_res_y, out_res_z,
                       out_res_scalar, out_zero_length, out_saturated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WD_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    beat_t b;
    beat_t d;
    int k, gmode;
    d = mk(OP_ADD, 0, 0, 0, 0, 0, 0, 0);
    d.drain = 1'b1;

    beats.push_back(mk(OP_ADD, QMAX, QMIN, 65536, QMAX, QMIN, -65536, 0));
    beats.push_back(mk(OP_SUB, QMIN, QMAX, 0, QMAX, QMIN, 1, 0));
    beats.push_back(mk(OP_SCALE, QMAX, QMIN, 131072, 0, 0, 0, QMIN));
    beats.push_back(mk(OP_SCALE, 65536, -65536, 3, 0, 0, 0, 98304));
    beats.push_back(mk(OP_MUL, QMIN, QMAX, -1, QMIN, QMIN, -1, 0));
    beats.push_back(mk(OP_CROSS, 65536, 0, 0, 0, 65536, 0, 0));
    beats.push_back(mk(OP_CROSS, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN, 0));
    beats.push_back(mk(OP_DOT, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, 0));
    beats.push_back(mk(OP_DOT, -1, -1, -1, 1, 1, 1, 0));
    beats.push_back(mk(OP_LEN, QMIN, QMIN, QMIN, 0, 0, 0, 0));
    beats.push_back(mk(OP_LEN, 0, 0, 0, 0, 0, 0, 0));
    beats.push_back(mk(OP_NORM, 0, 0, 0, 5, 5, 5, 0));
    beats.push_back(mk(OP_NORM, 196608, -262144, 0, 0, 0, 0, 0));
    beats.push_back(mk(OP_NORM, 1, 0, 0, 0, 0, 0, 0));
    beats.push_back(mk(OP_ROT, 65536, 0, 0, 0, 0, 65536, 102944));
    beats.push_back(mk(OP_ROT, 65536, 131072, 0, 0, 0, 0, 205887));
    beats.push_back(mk(OP_ROT, QMAX, QMIN, QMAX, 1, 1, 1, QMIN));
    beats.push_back(mk(OP_ROT, 65536, 65536, 65536, 0, 65536, 0, QMAX));
    beats.push_back(mk(OP_ROT, 1000, -2000, 3000, -65536, 0, 0, -205887));
    beats.push_back(mk(OP_UNKNOWN, 1, 2, 3, 4, 5, 6, 7));
    beats.push_back(mk(OP_UNKNOWN_HI, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX));
    beats.push_back(d);

    for (int n = 0; n < 1300; n++) begin
      k = $urandom_range(0, 3);
      b.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
      b.ax = rand_comp(k); b.ay = rand_comp(k); b.az = rand_comp(k);
      b.bx = rand_comp(k); b.by = rand_comp(k); b.bz = rand_comp(k);
      b.sc = ($urandom_range(0, 3) == 0) ? rand_comp(k) : rand_comp(1);
      if (b.op inside {OP_NORM, OP_ROT} && $urandom_range(0, 15) == 0) begin
        if (b.op == OP_NORM) begin
          b.ax = '0; b.ay = '0; b.az = '0;
        end else begin
          b.bx = '0; b.by = '0; b.bz = '0;
        end
      end
      gmode = (n / 100) % 3;
      b.gap = (gmode == 0) ? 0 : (gmode == 1) ? $urandom_range(0, 7)
                                              : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : 0);
      b.drain = 1'b0;
      beats.push_back(b);
      if (n % 400 == 399) beats.push_back(d);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (beats.size() > 0 || start) @(negedge clk);
    while (expected_res.size() > 0) @(negedge clk);
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/v3vu_pkg.sv
hw/rtl/v3vu_isqrt.sv
hw/rtl/v3vu_div.sv
hw/rtl/v3vu_sincos.sv
hw/rtl/v3vu_back.sv
hw/rtl/vec3_fixed_point_vector_unit.sv
test/tb.sv
